/* src/hbs_pkg.sv */
// shared types for the half / bfloat16 / single format converter
// stage payload structs and the conversion selector codes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hbs_pkg;

  // conversion selector codes
  typedef enum logic [1:0] {
    REQ_BF16_TO_SGL = 2'd0,
    REQ_SGL_TO_BF16 = 2'd1,
    REQ_HALF_TO_SGL = 2'd2,
    REQ_SGL_TO_HALF = 2'd3
  } req_e;

  // exponent bias difference between single and half
  localparam logic [7:0] BIAS_DIFF = 8'd112;
  // single exponents at or below this flush to zero in half
  localparam logic [7:0] HALF_UNDER_EXP = 8'd112;
  // single exponents at or above this overflow to infinity in half
  localparam logic [7:0] HALF_OVER_EXP = 8'd143;
  // rounding increment on the 23-bit single mantissa for half
  localparam logic [23:0] HALF_RND = 24'h001000;
  localparam logic [14:0] HALF_INF = 15'h7c00;
  localparam logic [31:0] BF16_RND = 32'h0000_7fff;

  // stage 1 -> stage 2: decoded operand and classification
  typedef struct packed {
    req_e        kind;
    logic [31:0] op;
    logic [3:0]  h_shift;  // normalizing shift for a half subnormal
    logic        h_sub;    // half exponent field is zero
    logic        h_zero;   // half zero (exponent and mantissa zero)
    logic        h_inf;    // half exponent all ones
    logic        s_under;  // single flushes to zero in half
    logic        s_over;   // single overflows to infinity in half
  } dec_t;

  // stage 2 -> stage 3: computed fields ready for assembly
  typedef struct packed {
    req_e        kind;
    logic        sign_h;
    logic        sign_s;
    logic [15:0] bf_hi;    // bf16 source, or rounded bf16 result
    logic [7:0]  h_exp;    // single exponent for half to single
    logic [9:0]  h_man;    // single mantissa top bits for half to single
    logic        h_zero;
    logic [14:0] s_mag;    // half magnitude for single to half
    logic        s_under;
    logic        s_over;
  } ari_t;

endpackage

`default_nettype wire

/* src/half_bfloat_single_converter_core.sv */
// Converter between IEEE single, half and bfloat16 bit patterns. Each transaction
// carries a 32-bit operand and a 2-bit selector and yields one 32-bit word, with
// 16-bit results in the low half. The work runs in a three-stage pipeline
// (classify and leading-zero count, rounding adds and rebias, assembly into the
// output register): an accepted transaction passes the stage 1, stage 2 and
// output registers before out_valid_o rises, and one transaction is accepted every
// cycle while the output side takes them.
// A stall at the output backs up through the per-stage valid bits without loss.
// depends on hbs_pkg, hbs_decode, hbs_arith, hbs_pack
`timescale 1ns / 1ps
`default_nettype none

module half_bfloat_single_converter_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] operand_bits_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      result_bits_o
);

  hbs_pkg::dec_t dec_d, dec_q;
  hbs_pkg::ari_t ari_d, ari_q;
  logic [31:0]   res_d, res_q;
  hbs_pkg::req_e kind3_q;
  logic          v1_q, v2_q, v3_q;
  logic          rdy1, rdy2, rdy3;

  // per-stage advance enables
  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_ready_o    = rdy1;
  assign out_valid_o   = v3_q;
  assign result_bits_o = res_q;

  hbs_decode u_decode (
    .req_type_i     (req_type_i),
    .operand_bits_i (operand_bits_i),
    .dec_o          (dec_d)
  );

  hbs_arith u_arith (
    .dec_i (dec_q),
    .ari_o (ari_d)
  );

  hbs_pack u_pack (
    .ari_i    (ari_q),
    .result_o (res_d)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // stage payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) dec_q <= dec_d;
    if (rdy2 && v1_q)       ari_q <= ari_d;
    if (rdy3 && v2_q) begin
      res_q   <= res_d;
      kind3_q <= ari_q.kind;
    end
  end

  // an accepted transaction is in stage 1 on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted transaction missing from stage 1");

  // stage 2, when it advances, hands its transaction to stage 3
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && rdy3 |=> v3_q)
    else $error("stage 2 transaction lost on advance");

  // 16-bit results leave the upper half clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind3_q == hbs_pkg::REQ_SGL_TO_BF16 ||
                    kind3_q == hbs_pkg::REQ_SGL_TO_HALF)
    |-> result_bits_o[31:16] == 16'd0)
    else $error("16-bit result with nonzero upper half");

endmodule

`default_nettype wire

/* src/hbs_decode.sv */
// stage 1 logic: operand classification and half subnormal leading-zero count
// depends on hbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module hbs_decode (
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] operand_bits_i,
  output hbs_pkg::dec_t    dec_o
);

  logic [9:0] man;
  logic [3:0] shift;
  logic       found;

  assign man = operand_bits_i[9:0];

  // shifts needed to bring the leading one up to the hidden bit position
  always_comb begin
    shift = 4'd0;
    found = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (!found && man[i]) begin
        found = 1'b1;
        shift = 4'(10 - i);
      end
    end
  end

  // classification of both source formats
  always_comb begin
    dec_o.kind    = hbs_pkg::req_e'(req_type_i);
    dec_o.op      = operand_bits_i;
    dec_o.h_shift = shift;
    dec_o.h_sub   = (operand_bits_i[14:10] == 5'd0);
    dec_o.h_zero  = (operand_bits_i[14:10] == 5'd0) && (man == 10'd0);
    dec_o.h_inf   = (operand_bits_i[14:10] == 5'h1f);
    dec_o.s_under = (operand_bits_i[30:23] <= hbs_pkg::HALF_UNDER_EXP);
    dec_o.s_over  = (operand_bits_i[30:23] >= hbs_pkg::HALF_OVER_EXP);
  end

endmodule

`default_nettype wire

/* src/hbs_arith.sv */
// stage 2 logic: rounding adds, exponent rebias and subnormal normalization
// depends on hbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module hbs_arith (
  input  hbs_pkg::dec_t dec_i,
  output hbs_pkg::ari_t ari_o
);

  logic [31:0] bf_sum;
  logic [23:0] rnd_man;
  logic [7:0]  s_exp;
  logic [14:0] s_mag;

  // round to nearest even for bf16, wrapping at 32 bits
  assign bf_sum = dec_i.op + hbs_pkg::BF16_RND + {31'd0, dec_i.op[16]};

  // half-up rounding of the single mantissa, carry flows into the exponent
  assign rnd_man = {1'b0, dec_i.op[22:0]} + hbs_pkg::HALF_RND;
  assign s_exp   = dec_i.op[30:23] - hbs_pkg::BIAS_DIFF;
  assign s_mag   = {s_exp[4:0], 10'd0} + {4'd0, rnd_man[23:13]};

  always_comb begin
    ari_o.kind    = dec_i.kind;
    ari_o.sign_h  = dec_i.op[15];
    ari_o.sign_s  = dec_i.op[31];
    ari_o.bf_hi   = (dec_i.kind == hbs_pkg::REQ_BF16_TO_SGL) ? dec_i.op[15:0]
                                                              : bf_sum[31:16];
    ari_o.h_zero  = dec_i.h_zero;
    ari_o.s_mag   = s_mag;
    ari_o.s_under = dec_i.s_under;
    ari_o.s_over  = dec_i.s_over;
    // half exponent to single: subnormal, special or normal
    priority if (dec_i.h_sub) begin
      ari_o.h_exp = (hbs_pkg::BIAS_DIFF + 8'd1) - {4'd0, dec_i.h_shift};
      ari_o.h_man = 10'(dec_i.op[9:0] << dec_i.h_shift);
    end else if (dec_i.h_inf) begin
      ari_o.h_exp = 8'hff;
      ari_o.h_man = dec_i.op[9:0];
    end else begin
      ari_o.h_exp = {3'd0, dec_i.op[14:10]} + hbs_pkg::BIAS_DIFF;
      ari_o.h_man = dec_i.op[9:0];
    end
  end

endmodule

`default_nettype wire

/* src/hbs_pack.sv */
// stage 3 logic: special-case selection and assembly of the result word
// depends on hbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module hbs_pack (
  input  hbs_pkg::ari_t    ari_i,
  output logic [31:0]      result_o
);

  // pick the result layout by conversion kind
  always_comb begin
    unique case (ari_i.kind)
      hbs_pkg::REQ_BF16_TO_SGL: result_o = {ari_i.bf_hi, 16'd0};
      hbs_pkg::REQ_SGL_TO_BF16: result_o = {16'd0, ari_i.bf_hi};
      hbs_pkg::REQ_HALF_TO_SGL: begin
        if (ari_i.h_zero) begin
          result_o = {ari_i.sign_h, 31'd0};
        end else begin
          result_o = {ari_i.sign_h, ari_i.h_exp, ari_i.h_man, 13'd0};
        end
      end
      hbs_pkg::REQ_SGL_TO_HALF: begin
        priority if (ari_i.s_under) begin
          result_o = {16'd0, ari_i.sign_s, 15'd0};
        end else if (ari_i.s_over) begin
          result_o = {16'd0, ari_i.sign_s, hbs_pkg::HALF_INF};
        end else begin
          result_o = {16'd0, ari_i.sign_s, ari_i.s_mag};
        end
      end
      default: result_o = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* tb/half_bfloat_single_converter_core_tb.sv */
// testbench for half_bfloat_single_converter_core: directed and random conversions
// checked against an in-bench bit-exact converter model; depends on hbs_pkg and the core
`timescale 1ns / 1ps

module half_bfloat_single_converter_core_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 10;
  localparam int RANDOM_ITEMS   = 500;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  req_type_i;
  logic [31:0] operand_bits_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] result_bits_o;

  // converted words still owed by the core, oldest first
  logic [31:0] owed_words[$];
  int          fail_count;
  int          sent_count;
  int          checked_count;
  int          stall_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          sel_count[4];

  half_bfloat_single_converter_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .operand_bits_i (operand_bits_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_bits_o  (result_bits_o)
  );

  // clock generation
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // half to single: exact, subnormals normalized, inf/nan keep the payload
  function automatic logic [31:0] half_to_single(logic [31:0] w);
    logic [10:0] m;
    logic [7:0]  ex32;
    int          shifts;
    m      = {1'b0, w[9:0]};
    shifts = 0;
    if (w[14:10] == 5'd0) begin
      if (w[9:0] == 10'd0) return {w[15], 31'd0};
      for (int i = 0; i < 10; i++) begin
        if (m[10]) break;
        m = m << 1;
        shifts++;
      end
      ex32 = 8'd113 - 8'(shifts);
      return {w[15], ex32, m[9:0], 13'd0};
    end
    if (w[14:10] == 5'h1f) return {w[15], 8'hff, w[9:0], 13'd0};
    ex32 = {3'd0, w[14:10]} + hbs_pkg::BIAS_DIFF;
    return {w[15], ex32, w[9:0], 13'd0};
  endfunction

  // single to half: flush, saturate to inf, round half-up with carry into exponent
  function automatic logic [15:0] single_to_half(logic [31:0] w);
    int          e;
    logic [23:0] rnd_sum;
    logic [14:0] mag;
    e = int'(w[30:23]) - 112;
    if (e <= 0) return {w[31], 15'd0};
    if (e >= 31) return {w[31], hbs_pkg::HALF_INF};
    rnd_sum = {1'b0, w[22:0]} + hbs_pkg::HALF_RND;
    mag     = {e[4:0], 10'd0} + {4'd0, rnd_sum[23:13]};
    return {w[31], mag};
  endfunction

  // expected output word for one conversion request
  function automatic logic [31:0] convert_word(hbs_pkg::req_e kind, logic [31:0] w);
    logic [31:0] sum;
    case (kind)
      hbs_pkg::REQ_BF16_TO_SGL: return {w[15:0], 16'd0};
      hbs_pkg::REQ_SGL_TO_BF16: begin
        sum = w + hbs_pkg::BF16_RND + {31'd0, w[16]};
        return {16'd0, sum[31:16]};
      end
      hbs_pkg::REQ_HALF_TO_SGL: return half_to_single(w);
      default:                  return {16'd0, single_to_half(w)};
    endcase
  endfunction

  // input monitor, output checker and watchdog, all on the rising edge
  always @(posedge clk_i) begin
    logic [31:0] want;
    logic        moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        owed_words.push_back(convert_word(hbs_pkg::req_e'(req_type_i), operand_bits_i));
        sel_count[req_type_i]++;
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (owed_words.size() == 0) begin
          $error("unexpected transaction: result_bits %h with nothing owed", result_bits_o);
          fail_count++;
        end else begin
          want = owed_words.pop_front();
          checked_count++;
          if (result_bits_o !== want) begin
            $error("result_bits mismatch: expected %h actual %h", want, result_bits_o);
            fail_count++;
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL half_bfloat_single_converter_core");
        $finish;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i = ($urandom_range(99) >= recv_idle_pct);
  end

  // send one transaction, with random idle cycles ahead of it
  task automatic send_conversion(hbs_pkg::req_e kind, logic [31:0] w);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    req_type_i     = kind;
    operand_bits_i = w;
    sent_count++;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (owed_words.size() != 0) @(posedge clk_i);
  endtask

  // operand biased toward exponent and rounding boundaries of the chosen format
  function automatic logic [31:0] pick_operand(hbs_pkg::req_e kind);
    logic [31:0] r;
    logic [31:0] m;
    logic [7:0]  ex;
    logic [4:0]  hx;
    r = $urandom;
    m = $urandom;
    if ($urandom_range(3) == 0) return r;
    case (kind)
      hbs_pkg::REQ_SGL_TO_HALF: begin
        case ($urandom_range(7))
          0: ex = 8'd0;
          1: ex = 8'd111;
          2: ex = 8'd112;
          3: ex = 8'd113;
          4: ex = 8'd142;
          5: ex = 8'd143;
          6: ex = 8'd255;
          default: ex = 8'(112 + $urandom_range(31));
        endcase
        case ($urandom_range(3))
          0: m[22:0] = 23'h7fffff;
          1: m[22:0] = {10'h3ff, 13'h1000 + 13'($urandom_range(1)) - 13'd1};
          2: m[22:0] = {m[22:13], 1'b1, 12'd0};
          default: ;
        endcase
        return {r[31], ex, m[22:0]};
      end
      hbs_pkg::REQ_SGL_TO_BF16: begin
        case ($urandom_range(4))
          0: r[15:0] = 16'h7fff;
          1: r[15:0] = 16'h8000;
          2: r[15:0] = 16'h8001;
          3: r[30:16] = 15'h7fff;
          default: r[30:23] = 8'hff;
        endcase
        return r;
      end
      default: begin
        case ($urandom_range(4))
          0: hx = 5'd0;
          1: hx = 5'd1;
          2: hx = 5'd30;
          3: hx = 5'd31;
          default: hx = r[14:10];
        endcase
        case ($urandom_range(3))
          0: m[9:0] = 10'd0;
          1: m[9:0] = 10'd1;
          2: m[9:0] = 10'h3ff;
          default: ;
        endcase
        return {r[31:16], r[15], hx, m[9:0]};
      end
    endcase
  endfunction

  task automatic test_bf16_to_single();
    send_conversion(hbs_pkg::REQ_BF16_TO_SGL, 32'h0000_0000);
    send_conversion(hbs_pkg::REQ_BF16_TO_SGL, 32'h0000_ffff);
    send_conversion(hbs_pkg::REQ_BF16_TO_SGL, 32'hdead_3f80);  // upper half ignored
    send_conversion(hbs_pkg::REQ_BF16_TO_SGL, 32'hffff_8000);
  endtask

  task automatic test_single_to_bf16();
    send_conversion(hbs_pkg::REQ_SGL_TO_BF16, 32'h0000_0000);
    send_conversion(hbs_pkg::REQ_SGL_TO_BF16, 32'hffff_ffff);  // wraps to zero
    send_conversion(hbs_pkg::REQ_SGL_TO_BF16, 32'h3f80_8000);  // tie, even kept
    send_conversion(hbs_pkg::REQ_SGL_TO_BF16, 32'h3f81_8000);  // tie, odd rounds up
    send_conversion(hbs_pkg::REQ_SGL_TO_BF16, 32'h7f7f_ffff);  // carries into inf
    send_conversion(hbs_pkg::REQ_SGL_TO_BF16, 32'h7fc0_0001);  // nan, rounded like any other value
  endtask

  task automatic test_half_to_single();
    send_conversion(hbs_pkg::REQ_HALF_TO_SGL, 32'h0000_8000);  // negative zero
    send_conversion(hbs_pkg::REQ_HALF_TO_SGL, 32'hffff_0001);  // smallest subnormal, junk top
    send_conversion(hbs_pkg::REQ_HALF_TO_SGL, 32'h0000_03ff);  // largest subnormal
    send_conversion(hbs_pkg::REQ_HALF_TO_SGL, 32'h0000_7bff);
    send_conversion(hbs_pkg::REQ_HALF_TO_SGL, 32'h0000_7c00);  // infinity
    send_conversion(hbs_pkg::REQ_HALF_TO_SGL, 32'h0000_fe01);  // nan with payload
  endtask

  task automatic test_single_to_half();
    send_conversion(hbs_pkg::REQ_SGL_TO_HALF, 32'h8000_0001);  // subnormal flushes
    send_conversion(hbs_pkg::REQ_SGL_TO_HALF, 32'h387f_ffff);  // just under the normal range
    send_conversion(hbs_pkg::REQ_SGL_TO_HALF, 32'h3880_0000);  // smallest normal half
    send_conversion(hbs_pkg::REQ_SGL_TO_HALF, 32'h477f_e000);  // largest finite
    send_conversion(hbs_pkg::REQ_SGL_TO_HALF, 32'h477f_f000);  // rounding carry to inf
    send_conversion(hbs_pkg::REQ_SGL_TO_HALF, 32'hc780_0000);  // overflow
    send_conversion(hbs_pkg::REQ_SGL_TO_HALF, 32'h7fc0_0000);  // nan becomes inf
    send_conversion(hbs_pkg::REQ_SGL_TO_HALF, 32'hff80_0001);
  endtask

  task automatic test_random_mix(int n);
    hbs_pkg::req_e kind;
    for (int i = 0; i < n; i++) begin
      kind = hbs_pkg::req_e'($urandom_range(3));
      send_conversion(kind, pick_operand(kind));
    end
  endtask

  // sender holds off until the pipeline has fully emptied, then resumes
  task automatic test_drain_pause();
    test_random_mix(20);
    wait_drained();
    test_random_mix(20);
  endtask

  // stimulus sequence
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = hbs_pkg::REQ_BF16_TO_SGL;
    operand_bits_i = 32'd0;
    out_ready_i    = 1'b0;
    fail_count     = 0;
    sent_count     = 0;
    checked_count  = 0;
    stall_cycles   = 0;
    send_idle_pct  = 24;
    recv_idle_pct  = 55;
    for (int i = 0; i < 4; i++) sel_count[i] = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_bf16_to_single();
    test_single_to_bf16();
    test_half_to_single();
    test_single_to_half();
    test_random_mix(RANDOM_ITEMS);
    test_drain_pause();

    send_idle_pct = 55;
    recv_idle_pct = 24;
    test_random_mix(RANDOM_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(RANDOM_ITEMS);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d conversions (bf16->sgl %0d, sgl->bf16 %0d, half->sgl %0d, sgl->half %0d)",
             sent_count, sel_count[0], sel_count[1], sel_count[2], sel_count[3]);
    $display("with directed edge cases, a full drain pause and three stall profiles; %0d checked",
             checked_count);
    if (fail_count == 0) begin
      $display("PASS half_bfloat_single_converter_core");
    end else begin
      $display("FAIL half_bfloat_single_converter_core");
    end
    $finish;
  end

endmodule
